// ----- hdl/bounded_set_table_defines.svh -----
// Assertion macros for the bounded set table.
`ifndef BOUNDED_SET_TABLE_DEFINES_SVH
`define BOUNDED_SET_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, reset masks the check.
`define BST_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bounded_set_table: same-cycle check failed");

// Next-cycle implication, reset masks the check.
`define BST_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bounded_set_table: next-cycle check failed");

`else

`define BST_ASSERT_IMP(label, clk, rst, ante, cons)
`define BST_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- hdl/bst_pkg.sv -----
package bst_pkg;

  localparam int MAX_ITEMS_DEF = 64;
  localparam int ITEM_BITS_DEF = 32;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;
  localparam int CAP_W   = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_DUP    = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_ABSENT = 2'd3;

  typedef struct packed {
    logic               was_present;
    logic [1:0]         status;
    logic [COUNT_W-1:0] item_count;
    logic               is_full;
    logic               is_empty;
  } result_t;

endpackage

// ----- hdl/bst_mem.sv -----
module bst_mem #(
  parameter int DEPTH = bst_pkg::MAX_ITEMS_DEF,
  parameter int WIDTH = bst_pkg::ITEM_BITS_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/bst_ctrl.sv -----
module bst_ctrl #(
  parameter int MAX_ITEMS = bst_pkg::MAX_ITEMS_DEF,
  parameter int ITEM_BITS = bst_pkg::ITEM_BITS_DEF,
  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  operation,
  input  logic [bst_pkg::VALUE_W-1:0] item_value,
  input  logic [bst_pkg::CAP_W-1:0]   capacity_limit,
  output logic                        res_valid,
  input  logic                        res_take,
  output bst_pkg::result_t            res,
  output logic                        mem_rd_en,
  output logic [AW-1:0]               mem_rd_addr,
  input  logic [ITEM_BITS-1:0]        mem_rd_data,
  output logic                        mem_wr_en,
  output logic [AW-1:0]               mem_wr_addr,
  output logic [ITEM_BITS-1:0]        mem_wr_data
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int CW    = (CNT_W > bst_pkg::CAP_W) ? CNT_W : bst_pkg::CAP_W;
  localparam int VW    = (ITEM_BITS > bst_pkg::VALUE_W) ? ITEM_BITS : bst_pkg::VALUE_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_ACT  = 3'd2;
  localparam logic [2:0] S_MOVE = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0]           state;
  logic [1:0]           op;
  logic [ITEM_BITS-1:0] val;
  logic [CNT_W-1:0]     idx;
  logic                 pend;
  logic [AW-1:0]        pidx;
  logic                 found;
  logic [AW-1:0]        hit;
  logic [CNT_W-1:0]     count;
  logic [1:0]           status;

  logic [VW-1:0]        in_wide;
  logic                 hit_now;
  logic [CNT_W-1:0]     count_m1;
  logic [CW-1:0]        cap_ext;
  logic [CW-1:0]        cap_eff;
  logic                 count_full;

  assign in_wide  = VW'(item_value);
  assign hit_now  = pend && (mem_rd_data == val);
  assign count_m1 = count - CNT_W'(1);

  // Capacity above the array depth saturates to the depth.
  assign cap_ext    = CW'(capacity_limit);
  assign cap_eff    = (cap_ext > CW'(MAX_ITEMS)) ? CW'(MAX_ITEMS) : cap_ext;
  assign count_full = CW'(count) >= cap_eff;

  assign in_stall  = (state != S_IDLE);
  assign res_valid = (state == S_RESP);

  always_comb begin
    res.was_present = found;
    res.status      = status;
    res.item_count  = bst_pkg::COUNT_W'(count);
    res.is_full     = count_full;
    res.is_empty    = (count == '0);
  end

  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = idx[AW-1:0];
    mem_wr_en   = 1'b0;
    mem_wr_addr = count[AW-1:0];
    mem_wr_data = val;
    unique case (state)
      S_SCAN: begin
        if (!hit_now && (idx < count)) begin
          mem_rd_en = 1'b1;
        end
      end
      S_ACT: begin
        if (op == bst_pkg::OP_INSERT && !found && !count_full) begin
          mem_wr_en = 1'b1;
        end
        // fetch the last entry to fill the hole left by the removal
        if (op == bst_pkg::OP_REMOVE && found) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = count_m1[AW-1:0];
        end
      end
      S_MOVE: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = hit;
        mem_wr_data = mem_rd_data;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= operation;
            val   <= in_wide[ITEM_BITS-1:0];
            idx   <= '0;
            pend  <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // compare the entry read last cycle while issuing the next read
          if (hit_now) begin
            found <= 1'b1;
            hit   <= pidx;
            pend  <= 1'b0;
            state <= S_ACT;
          end else if (idx < count) begin
            pend <= 1'b1;
            pidx <= idx[AW-1:0];
            idx  <= idx + CNT_W'(1);
          end else begin
            found <= 1'b0;
            pend  <= 1'b0;
            state <= S_ACT;
          end
        end
        S_ACT: begin
          status <= bst_pkg::ST_DONE;
          state  <= S_RESP;
          if (op == bst_pkg::OP_INSERT) begin
            if (found) begin
              status <= bst_pkg::ST_DUP;
            end else if (count_full) begin
              status <= bst_pkg::ST_FULL;
            end else begin
              count <= count + CNT_W'(1);
            end
          end else if (op == bst_pkg::OP_REMOVE) begin
            if (!found) begin
              status <= bst_pkg::ST_ABSENT;
            end else begin
              state <= S_MOVE;
            end
          end
        end
        S_MOVE: begin
          count <= count_m1;
          state <= S_RESP;
        end
        S_RESP: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/bounded_set_table.sv -----
// Bounded set table: a set of distinct values held in a packed on-chip array.
// Request channel: in_valid / in_stall with operation (insert, remove, query;
// code 3 acts as a query) and item_value. Result channel: out_valid /
// out_stall with was_present, status, item_count, is_full and is_empty.
// Every request gives exactly one result, in request order.
// Each request scans the stored entries one per cycle through the array's
// single read port, stopping at the first match. After the scan the request
// is acted on, a remove that hits then moves the last entry into the freed
// slot, and the result waits in the response state until it is handed to
// the output register. One request is in flight at a time, so a new request
// is not taken before the previous one has been handed on.
// The next request is accepted once the previous result has been handed to
// the output register, even while that result is still stalled there.
// capacity_limit is written with cfg_wr_en; the user must write it only while the block
// is idle, which the block does not enforce. Values above the array depth act as the depth.
// Reset empties the set and sets capacity_limit to 64; there is no clearing
// pass, the array contents are ignored until written.
// While out_stall holds, the result stays put and at most one further
// request is taken and finished, and in_stall stays high until the output drains.
`include "bounded_set_table_defines.svh"

module bounded_set_table #(
  parameter int MAX_ITEMS = bst_pkg::MAX_ITEMS_DEF,
  parameter int ITEM_BITS = bst_pkg::ITEM_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [bst_pkg::CAP_W-1:0]    capacity_limit,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   operation,
  input  logic [bst_pkg::VALUE_W-1:0]  item_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         was_present,
  output logic [1:0]                   status,
  output logic [bst_pkg::COUNT_W-1:0]  item_count,
  output logic                         is_full,
  output logic                         is_empty
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

  logic [bst_pkg::CAP_W-1:0] cap;
  logic                      res_valid;
  logic                      res_take;
  bst_pkg::result_t          res;
  bst_pkg::result_t          out_res;

  logic                 mem_rd_en;
  logic [AW-1:0]        mem_rd_addr;
  logic [ITEM_BITS-1:0] mem_rd_data;
  logic                 mem_wr_en;
  logic [AW-1:0]        mem_wr_addr;
  logic [ITEM_BITS-1:0] mem_wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= bst_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      cap <= capacity_limit;
    end
  end

  bst_ctrl #(
    .MAX_ITEMS(MAX_ITEMS),
    .ITEM_BITS(ITEM_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .item_value    (item_value),
    .capacity_limit(cap),
    .res_valid     (res_valid),
    .res_take      (res_take),
    .res           (res),
    .mem_rd_en     (mem_rd_en),
    .mem_rd_addr   (mem_rd_addr),
    .mem_rd_data   (mem_rd_data),
    .mem_wr_en     (mem_wr_en),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_data   (mem_wr_data)
  );

  bst_mem #(
    .DEPTH(MAX_ITEMS),
    .WIDTH(ITEM_BITS)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

  // Load a ready result into the output register whenever it is empty or draining this cycle.
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

  assign was_present = out_res.was_present;
  assign status      = out_res.status;
  assign item_count  = out_res.item_count;
  assign is_full     = out_res.is_full;
  assign is_empty    = out_res.is_empty;

  `BST_ASSERT_IMP(a_refused_is_full, clk, rst, out_valid && status == bst_pkg::ST_FULL, is_full)
  `BST_ASSERT_IMP(a_dup_was_present, clk, rst, out_valid && status == bst_pkg::ST_DUP, was_present)
  `BST_ASSERT_IMP(a_absent_not_present, clk, rst, out_valid && status == bst_pkg::ST_ABSENT, !was_present)
  `BST_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)

endmodule
